@@ rtl/core/tps_pkg.sv @@
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants for the thin-plate-spline warp
// Entry and kernel-result types, codes, widths and the log2 table builder.
// ----------------------------------------------------------------------------
package tps_pkg;

  // Default sizes
  localparam int MaxCentresDef   = 64;
  localparam int LogTableBitsDef = 6;

  // Fixed field widths
  localparam int CoordW  = 24;
  localparam int WeightW = 32;
  localparam int R2W     = 50;   // (dx^2 + dy^2), |dx| <= 2^24
  localparam int TermW   = 62;   // signed, magnitude capped at 2^60
  localparam int AccW    = 64;

  // ln(2)/2 in Q.16
  localparam logic [14:0] Ln2HalfQ16 = 15'd22713;

  // Saturation bound for products, terms and accumulator
  localparam logic signed [AccW-1:0] SatCap = 64'sd1 <<< 60;

  // Input opcodes
  localparam logic OpLoad = 1'b0;
  localparam logic OpEval = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_AFFINE_XX   = 3'd0,
    REG_AFFINE_XY   = 3'd1,
    REG_AFFINE_YX   = 3'd2,
    REG_AFFINE_YY   = 3'd3,
    REG_OFFSET_X    = 3'd4,
    REG_OFFSET_Y    = 3'd5,
    REG_POINT_COUNT = 3'd6
  } reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AFFINE,
    ST_SUM,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // One centre held in a ring cell
  typedef struct packed {
    logic signed [CoordW-1:0]  cx;
    logic signed [CoordW-1:0]  cy;
    logic signed [WeightW-1:0] wx;
    logic signed [WeightW-1:0] wy;
  } entry_t;

  // Kernel output toward the accumulator
  typedef struct packed {
    logic                    valid;
    logic signed [TermW-1:0] term_x;
    logic signed [TermW-1:0] term_y;
  } kres_t;

  // log2 fraction table entry, Q.16, built by repeated squaring
  function automatic logic [16:0] log_entry(input int idx, input int bits);
    logic [63:0] v;
    logic [16:0] res;
    if (idx == (1 << bits)) begin
      return 17'd65536;
    end
    v   = (64'd1 << 30) + (64'(idx) << (30 - bits));
    res = '0;
    for (int k = 0; k < 16; k++) begin
      v   = (v * v) >> 30;
      res = res << 1;
      if (v >= (64'd1 << 31)) begin
        v      = v >> 1;
        res[0] = 1'b1;
      end
    end
    return res;
  endfunction

  // Add a term and clamp to +/- 2^60
  function automatic logic signed [AccW-1:0] acc_add(input logic signed [AccW-1:0] acc,
                                                    input logic signed [TermW-1:0] term);
    logic signed [AccW-1:0] s;
    s = acc + AccW'(term);
    if (s > SatCap) begin
      return SatCap;
    end
    if (s < -SatCap) begin
      return -SatCap;
    end
    return s;
  endfunction

  // Round Q.16 to Q16.8 and saturate to 24 bits
  function automatic logic signed [CoordW-1:0] finish(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] v;
    v = (acc + 64'sd128) >>> 8;
    if (v > 64'sd8388607) begin
      return 24'sh7fffff;
    end
    if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[CoordW-1:0];
  endfunction

endpackage

@@ rtl/core/tps_cell.sv @@
// ----------------------------------------------------------------------------
// tps_cell: one centre slot of the rotating table ring
// Takes a load beat for its own slot, or the neighbor's entry while rotating.
// ----------------------------------------------------------------------------
module tps_cell (
  input  logic            clk_i,
  input  logic            load_i,
  input  tps_pkg::entry_t load_data_i,
  input  logic            shift_i,
  input  tps_pkg::entry_t next_i,
  output tps_pkg::entry_t entry_o
);

  tps_pkg::entry_t entry_q, entry_d;

  // load wins; loads only happen while the ring stands still
  always_comb begin
    entry_d = entry_q;
    if (load_i) begin
      entry_d = load_data_i;
    end else if (shift_i) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ rtl/core/tps_kernel.sv @@
// ----------------------------------------------------------------------------
// tps_kernel: pipelined radial kernel and weighting
// One centre per cycle: r^2, log2 by table, phi = r^2 ln r, weighted terms.
// ----------------------------------------------------------------------------
module tps_kernel #(
  parameter int LOG_TABLE_BITS = tps_pkg::LogTableBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic                               use_i,
  input  logic signed [tps_pkg::CoordW-1:0]  x_i,
  input  logic signed [tps_pkg::CoordW-1:0]  y_i,
  input  tps_pkg::entry_t                    entry_i,
  output tps_pkg::kres_t                     res_o,
  output logic                               busy_o
);

  localparam int L     = LOG_TABLE_BITS;
  localparam int TabN  = (1 << L) + 1;
  localparam int RemW  = 32 - L;
  localparam int R2W   = tps_pkg::R2W;
  localparam int WW    = tps_pkg::WeightW;
  localparam int NSt   = 13;
  localparam int HW    = 23;
  localparam int PhiW  = 58;
  localparam int RawW  = 75;

  // log2 fraction table, constant
  logic [16:0] log_tab [TabN];
  for (genvar g = 0; g < TabN; g++) begin : g_tab
    assign log_tab[g] = tps_pkg::log_entry(g, L);
  end

  function automatic logic [5:0] msb_pos(input logic [R2W-1:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < R2W; i++) begin
      if (v[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  // stage valid chain
  logic [NSt:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSt-1:1], valid_i};
    end
  end

  assign busy_o = |vld_q;

  // payload along the pipe
  logic [NSt:1]              use_q;
  logic signed [WW-1:0]      wx_q [NSt-1:1];
  logic signed [WW-1:0]      wy_q [NSt-1:1];
  logic [24:0]               adx1_q, ady1_q;
  logic [R2W-1:0]            sqx2_q, sqy2_q;
  logic [R2W-1:0]            r2_q [9:3];
  logic [5:0]                e_q [7:4];
  logic [31:0]               frac5_q;
  logic [16:0]               t0_6_q, diff6_q, t0_7_q;
  logic [RemW-1:0]           rem6_q;
  logic [16+RemW:0]          prod7_q;
  logic [23:0]               alg8_q;
  logic [NSt:8]              neg_q;
  logic [HW-1:0]             h9_q;
  logic [HW+31:0]            phl10_q;
  logic [HW+R2W-33:0]        phh10_q;
  logic [PhiW-1:0]           phi11_q;
  logic [63:0]               mlx12_q, mly12_q;
  logic [WW+PhiW-33:0]       mhx12_q, mhy12_q;
  logic                      flx12_q, fly12_q;
  logic signed [tps_pkg::TermW-1:0] tx13_q, ty13_q;

  // combinational pieces per stage
  logic signed [24:0] dx, dy;
  logic [R2W-1:0]     norm5;
  logic [L-1:0]       idx6;
  logic [L:0]         ia6, ib6;
  logic [16:0]        t1_6, t0_6;
  logic [16:0]        tf8;
  logic signed [24:0] lg8;
  logic [HW+15:0]     hp9;
  logic [WW-1:0]      wmx12, wmy12;
  logic [RawW-1:0]    rawx13, rawy13;
  logic [60:0]        magx13, magy13;

  always_comb begin
    dx     = 25'(x_i) - 25'(entry_i.cx);
    dy     = 25'(y_i) - 25'(entry_i.cy);
    norm5  = r2_q[4] << (6'd49 - e_q[4]);
    idx6   = frac5_q[31 -: L];
    ia6    = {1'b0, idx6};
    ib6    = ia6 + 1'b1;
    t0_6   = log_tab[ia6];
    t1_6   = log_tab[ib6];
    tf8    = t0_7_q + 17'(prod7_q >> RemW);
    lg8    = $signed({3'b000, e_q[7], 16'h0000}) - 25'sd1048576 + $signed({8'h00, tf8});
    hp9    = {15'd0, alg8_q} * {24'd0, tps_pkg::Ln2HalfQ16};
    wmx12  = wx_q[11][WW-1] ? WW'(-wx_q[11]) : WW'(wx_q[11]);
    wmy12  = wy_q[11][WW-1] ? WW'(-wy_q[11]) : WW'(wy_q[11]);
    rawx13 = (RawW'(mhx12_q) << 16) + RawW'(mlx12_q >> 16);
    rawy13 = (RawW'(mhy12_q) << 16) + RawW'(mly12_q >> 16);
    magx13 = (rawx13 > RawW'(64'd1 << 60)) ? (61'd1 << 60) : rawx13[60:0];
    magy13 = (rawy13 > RawW'(64'd1 << 60)) ? (61'd1 << 60) : rawy13[60:0];
  end

  always_ff @(posedge clk_i) begin
    // s1: distances
    adx1_q   <= dx[24] ? 25'(-dx) : 25'(dx);
    ady1_q   <= dy[24] ? 25'(-dy) : 25'(dy);
    use_q[1] <= use_i;
    wx_q[1]  <= entry_i.wx;
    wy_q[1]  <= entry_i.wy;
    for (int s = 2; s < NSt; s++) begin
      wx_q[s] <= wx_q[s-1];
      wy_q[s] <= wy_q[s-1];
    end
    // s2: squares
    sqx2_q <= R2W'(adx1_q * adx1_q);
    sqy2_q <= R2W'(ady1_q * ady1_q);
    use_q[2] <= use_q[1];
    // s3: r^2, zero distance contributes nothing
    r2_q[3]  <= sqx2_q + sqy2_q;
    use_q[3] <= use_q[2] && ((sqx2_q | sqy2_q) != '0);
    for (int s = 4; s <= 9; s++) begin
      r2_q[s] <= r2_q[s-1];
    end
    for (int s = 4; s <= NSt; s++) begin
      use_q[s] <= use_q[s-1];
    end
    // s4: leading one
    e_q[4] <= msb_pos(r2_q[3]);
    for (int s = 5; s <= 7; s++) begin
      e_q[s] <= e_q[s-1];
    end
    // s5: normalize
    frac5_q <= norm5[48:17];
    // s6: table pair
    t0_6_q  <= t0_6;
    diff6_q <= t1_6 - t0_6;
    rem6_q  <= frac5_q[RemW-1:0];
    // s7: interpolation product
    prod7_q <= diff6_q * rem6_q;
    t0_7_q  <= t0_6_q;
    // s8: log2 with sign
    neg_q[8] <= lg8[24];
    alg8_q   <= lg8[24] ? 24'(-lg8) : 24'(lg8);
    for (int s = 9; s <= NSt; s++) begin
      neg_q[s] <= neg_q[s-1];
    end
    // s9: scale by ln2/2
    h9_q <= hp9[HW+15:16];
    // s10: h * r^2 partial products
    phl10_q <= h9_q * r2_q[9][31:0];
    phh10_q <= h9_q * r2_q[9][R2W-1:32];
    // s11: phi
    phi11_q <= (PhiW'(phh10_q) << 16) + PhiW'(phl10_q >> 16);
    // s12: weight partial products
    mlx12_q <= wmx12 * phi11_q[31:0];
    mhx12_q <= wmx12 * phi11_q[PhiW-1:32];
    mly12_q <= wmy12 * phi11_q[31:0];
    mhy12_q <= wmy12 * phi11_q[PhiW-1:32];
    flx12_q <= wx_q[11][WW-1] ^ neg_q[11];
    fly12_q <= wy_q[11][WW-1] ^ neg_q[11];
    // s13: capped signed terms
    tx13_q <= flx12_q ? -$signed({1'b0, magx13}) : $signed({1'b0, magx13});
    ty13_q <= fly12_q ? -$signed({1'b0, magy13}) : $signed({1'b0, magy13});
  end

  assign res_o.valid  = vld_q[NSt] && use_q[NSt];
  assign res_o.term_x = tx13_q;
  assign res_o.term_y = ty13_q;

endmodule

@@ rtl/core/thin_plate_spline_warp_eval.sv @@
// ----------------------------------------------------------------------------
// thin_plate_spline_warp_eval: fixed-point thin-plate-spline warp
// Centres rotate through a ring of cells past one pipelined kernel.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_stall_o  | opcode, slot, coord_x/y, load_weight_x/y
//  out     | output    | out_valid_o / out_stall_i| warped_x, warped_y
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  A load beat is written into its slot's cell as it is accepted. An evaluate
//  beat is accepted, passes the affine and accumulator-seed states, then one
//  ring rotation of MAX_CENTRES centres through the kernel, a drain of the 13
//  kernel stages, and a final state that writes the result.
//  Reset clears the configuration registers and control; table cells are valid once loaded.
//  The input stalls while an evaluation runs; a finished result may wait in
//  the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module thin_plate_spline_warp_eval #(
  parameter int MAX_CENTRES    = tps_pkg::MaxCentresDef,
  parameter int LOG_TABLE_BITS = tps_pkg::LogTableBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic [5:0]                        slot_i,
  input  logic signed [23:0]                coord_x_i,
  input  logic signed [23:0]                coord_y_i,
  input  logic signed [31:0]                load_weight_x_i,
  input  logic signed [31:0]                load_weight_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [23:0]                warped_x_o,
  output logic signed [23:0]                warped_y_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [2:0]                        cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);

  localparam int N    = MAX_CENTRES;
  localparam int CW   = (N > 1) ? $clog2(N) : 1;
  localparam int EW   = ($clog2(N + 1) > 7) ? $clog2(N + 1) : 7;
  localparam int SW   = (CW > 6) ? CW : 6;
  localparam int AccW = tps_pkg::AccW;

  // configuration registers
  logic signed [31:0] axx_q, axy_q, ayx_q, ayy_q;
  logic signed [23:0] offx_q, offy_q;
  logic [6:0]         count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axx_q   <= '0;
      axy_q   <= '0;
      ayx_q   <= '0;
      ayy_q   <= '0;
      offx_q  <= '0;
      offy_q  <= '0;
      count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tps_pkg::REG_AFFINE_XX:   axx_q   <= cfg_data_i;
        tps_pkg::REG_AFFINE_XY:   axy_q   <= cfg_data_i;
        tps_pkg::REG_AFFINE_YX:   ayx_q   <= cfg_data_i;
        tps_pkg::REG_AFFINE_YY:   ayy_q   <= cfg_data_i;
        tps_pkg::REG_OFFSET_X:    offx_q  <= cfg_data_i[23:0];
        tps_pkg::REG_OFFSET_Y:    offy_q  <= cfg_data_i[23:0];
        tps_pkg::REG_POINT_COUNT: count_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // sequencer
  tps_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            in_acc, load_acc, eval_acc, run, kern_busy, out_load;
  tps_pkg::kres_t  kres;

  assign in_stall_o = (state_q != tps_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_acc   = in_acc && (opcode_i == tps_pkg::OpLoad);
  assign eval_acc   = in_acc && (opcode_i == tps_pkg::OpEval);
  assign run        = (state_q == tps_pkg::ST_RUN);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    out_load = 1'b0;
    case (state_q)
      tps_pkg::ST_IDLE: begin
        if (eval_acc) begin
          state_d = tps_pkg::ST_AFFINE;
        end
      end
      tps_pkg::ST_AFFINE: state_d = tps_pkg::ST_SUM;
      tps_pkg::ST_SUM: begin
        cnt_d   = '0;
        state_d = tps_pkg::ST_RUN;
      end
      tps_pkg::ST_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(N - 1)) begin
          state_d = tps_pkg::ST_DRAIN;
        end
      end
      tps_pkg::ST_DRAIN: begin
        if (!kern_busy) begin
          state_d = tps_pkg::ST_DONE;
        end
      end
      tps_pkg::ST_DONE: begin
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = tps_pkg::ST_IDLE;
        end
      end
      default: state_d = tps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tps_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // query point
  logic signed [23:0] x_q, y_q;
  always_ff @(posedge clk_i) begin
    if (eval_acc) begin
      x_q <= coord_x_i;
      y_q <= coord_y_i;
    end
  end

  // centre ring: cell i takes cell i+1 while rotating
  tps_pkg::entry_t cells [N];
  tps_pkg::entry_t load_entry;

  assign load_entry = '{cx: coord_x_i, cy: coord_y_i,
                        wx: load_weight_x_i, wy: load_weight_y_i};

  for (genvar g = 0; g < N; g++) begin : g_ring
    tps_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (load_acc && (SW'(slot_i) == SW'(g))),
      .load_data_i(load_entry),
      .shift_i    (run),
      .next_i     (cells[(g + 1) % N]),
      .entry_o    (cells[g])
    );
  end

  // centres in use
  logic [EW-1:0] count_e, n_eff;
  assign count_e = EW'(count_q);
  assign n_eff   = (count_e > EW'(N)) ? EW'(N) : count_e;

  tps_kernel #(
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_kernel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(run),
    .use_i  (EW'(cnt_q) < n_eff),
    .x_i    (x_q),
    .y_i    (y_q),
    .entry_i(cells[0]),
    .res_o  (kres),
    .busy_o (kern_busy)
  );

  // affine products, then accumulator seed, then kernel terms
  logic signed [55:0]     pxx_q, pxy_q, pyx_q, pyy_q;
  logic signed [AccW-1:0] accx_q, accy_q;

  always_ff @(posedge clk_i) begin
    if (state_q == tps_pkg::ST_AFFINE) begin
      pxx_q <= axx_q * x_q;
      pxy_q <= axy_q * y_q;
      pyx_q <= ayx_q * x_q;
      pyy_q <= ayy_q * y_q;
    end
    if (state_q == tps_pkg::ST_SUM) begin
      accx_q <= (AccW'(x_q) <<< 8) + AccW'(pxx_q >>> 8) + AccW'(pxy_q >>> 8)
                + (AccW'(offx_q) <<< 8);
      accy_q <= (AccW'(y_q) <<< 8) + AccW'(pyx_q >>> 8) + AccW'(pyy_q >>> 8)
                + (AccW'(offy_q) <<< 8);
    end else if (kres.valid) begin
      accx_q <= tps_pkg::acc_add(accx_q, kres.term_x);
      accy_q <= tps_pkg::acc_add(accy_q, kres.term_y);
    end
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      warped_x_o <= tps_pkg::finish(accx_q);
      warped_y_o <= tps_pkg::finish(accy_q);
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_term_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kres.valid |-> (state_q == tps_pkg::ST_RUN || state_q == tps_pkg::ST_DRAIN))
    else $error("kernel term outside evaluation window");

  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tps_pkg::ST_DONE |-> !kern_busy)
    else $error("result written while kernel still busy");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == tps_pkg::ST_DONE))
    else $error("result beat without finished evaluation");

  a_ring_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tps_pkg::ST_DRAIN) |-> (cnt_q == '0 || N == (1 << CW)) || cnt_q == CW'(N))
    else $error("ring not back at home position");

endmodule

@@ verif/thin_plate_spline_warp_eval_test.sv @@
// ----------------------------------------------------------------------------
// thin_plate_spline_warp_eval_test: self-checking bench for the TPS warp
// Loads centre entries and evaluates query points through the in/out beat
// channels with random gaps and stalls. Configuration changes happen between
// phases while the block is idle. Every result is checked against a local
// fixed-point predictor of the warp or, for known directed rows, a given value.
// ----------------------------------------------------------------------------
module thin_plate_spline_warp_eval_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tps_pkg::*;

  localparam int          NumCentres  = 64;
  localparam int          NumPhases   = 8;
  localparam int          PhaseItems  = 242;
  localparam int          DrainCycles = 120;
  localparam int          HoldCycles  = 1500;
  localparam longint      CycleLimit  = 1500000;
  localparam logic [2:0]  RegUnmapped = 3'd7;
  localparam longint unsigned Cap     = 64'd1 << 60;

  // Directed stimulus row
  typedef struct {
    logic               op;
    logic [5:0]         slot;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    bit                 known;
    logic signed [23:0] ex;
    logic signed [23:0] ey;
  } dir_row_t;

  typedef struct {
    logic signed [23:0] wx;
    logic signed [23:0] wy;
  } warp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic opcode_i = OpLoad;
  logic [5:0] slot_i = '0;
  logic signed [23:0] coord_x_i = '0;
  logic signed [23:0] coord_y_i = '0;
  logic signed [31:0] load_weight_x_i = '0;
  logic signed [31:0] load_weight_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [23:0] warped_x_o;
  logic signed [23:0] warped_y_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // Predictor state
  logic [16:0]        log_frac [0:NumCentres];
  logic [31:0]        cfg_reg  [0:6];
  logic signed [23:0] cen_x    [0:NumCentres-1];
  logic signed [23:0] cen_y    [0:NumCentres-1];
  logic signed [31:0] wgt_x    [0:NumCentres-1];
  logic signed [31:0] wgt_y    [0:NumCentres-1];
  bit                 loaded   [0:NumCentres-1];

  warp_t    pending_warps[$];
  dir_row_t dir_tab[$];
  int       fail_count = 0;
  bit       no_idle = 1'b0;
  bit       hold_req = 1'b0;
  longint   cycles = 0;

  thin_plate_spline_warp_eval DUT (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic void build_log_frac();
    longint unsigned v;
    logic [16:0] acc;
    for (int i = 0; i <= NumCentres; i++) begin
      if (i == NumCentres) begin
        log_frac[i] = 17'd65536;
      end else begin
        v   = (64'd1 << 30) + (longint'(i) << 24);
        acc = '0;
        for (int k = 0; k < 16; k++) begin
          v   = (v * v) >> 30;
          acc = acc << 1;
          if (v >= (64'd1 << 31)) begin
            v      = v >> 1;
            acc[0] = 1'b1;
          end
        end
        log_frac[i] = acc;
      end
    end
  endfunction

  // floor(a*b / 2^16) capped at 2^60
  function automatic longint unsigned q16_mul_sat(longint unsigned a, longint unsigned b);
    longint unsigned hi, r;
    hi = a * (b >> 32);
    if (hi >= (64'd1 << 44)) return Cap;
    r = (hi << 16) + ((a * (b & 64'hffff_ffff)) >> 16);
    return (r > Cap) ? Cap : r;
  endfunction

  function automatic longint log2_q16(longint unsigned r2);
    int e;
    longint unsigned norm, frac, idx, rem, t0, t1;
    e = 63;
    while (e > 0 && !r2[e]) e--;
    norm = (e >= 32) ? (r2 >> (e - 32)) : (r2 << (32 - e));
    frac = norm & 64'hffff_ffff;
    idx  = frac >> 26;
    rem  = frac & ((64'd1 << 26) - 1);
    t0   = log_frac[idx];
    t1   = log_frac[idx + 1];
    t0   = t0 + (((t1 - t0) * rem) >> 26);
    return (longint'(e) - 16) * 65536 + longint'(t0);
  endfunction

  function automatic longint clamp_sum(longint v);
    if (v > longint'(Cap)) return longint'(Cap);
    if (v < -longint'(Cap)) return -longint'(Cap);
    return v;
  endfunction

  function automatic longint weigh(logic signed [31:0] w, longint unsigned phi, bit neg);
    longint wl, t;
    wl = w;
    t  = longint'(q16_mul_sat((wl < 0) ? longint'(-wl) : wl, phi));
    return ((wl < 0) != neg) ? -t : t;
  endfunction

  function automatic logic signed [23:0] round_q8(longint acc);
    longint v;
    v = (acc + 128) >>> 8;
    if (v > 8388607) return 24'sh7fffff;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic int used_centres();
    int n;
    n = cfg_reg[REG_POINT_COUNT][6:0];
    return (n > NumCentres) ? NumCentres : n;
  endfunction

  function automatic warp_t warp_point(logic signed [23:0] px, logic signed [23:0] py);
    longint x, y, ax, ay, dx, dy, lg;
    longint unsigned r2, h, phi;
    bit neg;
    warp_t w;
    x  = px;
    y  = py;
    ax = x * 256 + ((longint'(signed'(cfg_reg[REG_AFFINE_XX])) * x) >>> 8)
         + ((longint'(signed'(cfg_reg[REG_AFFINE_XY])) * y) >>> 8)
         + longint'(signed'(cfg_reg[REG_OFFSET_X][23:0])) * 256;
    ay = y * 256 + ((longint'(signed'(cfg_reg[REG_AFFINE_YX])) * x) >>> 8)
         + ((longint'(signed'(cfg_reg[REG_AFFINE_YY])) * y) >>> 8)
         + longint'(signed'(cfg_reg[REG_OFFSET_Y][23:0])) * 256;
    for (int i = 0; i < used_centres(); i++) begin
      dx = x - longint'(cen_x[i]);
      dy = y - longint'(cen_y[i]);
      r2 = dx * dx + dy * dy;
      // zero distance contributes nothing
      if (r2 != 0) begin
        lg  = log2_q16(r2);
        neg = lg < 0;
        h   = (longint'(neg ? -lg : lg) * 22713) >> 16;
        phi = q16_mul_sat(h, r2);
        ax  = clamp_sum(ax + weigh(wgt_x[i], phi, neg));
        ay  = clamp_sum(ay + weigh(wgt_y[i], phi, neg));
      end
    end
    w.wx = round_q8(ax);
    w.wy = round_q8(ay);
    return w;
  endfunction

  // Contiguous loaded prefix; evaluation may only read loaded cells
  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < NumCentres && loaded[n]) n++;
    return n;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic idle_gap();
    int g;
    g = no_idle ? 0 : $urandom_range(0, 17);
    if (g > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_beat(dir_row_t r);
    warp_t w;
    idle_gap();
    @(negedge clk_i);
    in_valid_i      = 1'b1;
    opcode_i        = r.op;
    slot_i          = r.slot;
    coord_x_i       = r.x;
    coord_y_i       = r.y;
    load_weight_x_i = r.wx;
    load_weight_y_i = r.wy;
    do @(posedge clk_i); while (in_stall_o);
    if (r.op == OpLoad) begin
      cen_x[r.slot]  = r.x;
      cen_y[r.slot]  = r.y;
      wgt_x[r.slot]  = r.wx;
      wgt_y[r.slot]  = r.wy;
      loaded[r.slot] = 1'b1;
    end else begin
      if (r.known) begin
        w.wx = r.ex;
        w.wy = r.ey;
      end else begin
        w = warp_point(r.x, r.y);
      end
      pending_warps.push_back(w);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_warps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= REG_POINT_COUNT) cfg_reg[idx] = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic add_row(logic op, logic [5:0] slot, logic signed [23:0] x,
                         logic signed [23:0] y, logic signed [31:0] wx,
                         logic signed [31:0] wy, bit known);
    dir_row_t r;
    r.op = op; r.slot = slot; r.x = x; r.y = y; r.wx = wx; r.wy = wy;
    r.known = known; r.ex = x; r.ey = y;
    dir_tab.push_back(r);
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 2))
      0: return 24'($urandom);
      1: return 24'(signed'($urandom_range(0, 4000)) - 2000);
      default: return 24'(signed'($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_weight();
    if ($urandom_range(0, 3) == 0) return 32'($urandom);
    return 32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17));
  endfunction

  function automatic dir_row_t rand_row();
    dir_row_t r;
    int pre, c;
    pre     = loaded_prefix();
    r.known = 1'b0;
    r.wx    = rand_weight();
    r.wy    = rand_weight();
    r.x     = rand_coord();
    r.y     = rand_coord();
    r.op    = ($urandom_range(0, 9) < 7) ? OpEval : OpLoad;
    // an eval that would touch an unloaded cell becomes a load instead
    if (r.op == OpEval && used_centres() > pre) r.op = OpLoad;
    if (r.op == OpLoad) begin
      r.slot = (pre < NumCentres && $urandom_range(0, 1)) ? 6'(pre) : 6'($urandom);
    end else begin
      r.slot = 6'($urandom);
      // land exactly on a centre now and then
      if (used_centres() > 0 && $urandom_range(0, 4) == 0) begin
        c   = $urandom_range(0, used_centres() - 1);
        r.x = cen_x[c];
        r.y = cen_y[c];
      end
    end
    return r;
  endfunction

  task automatic configure(int ph);
    int pre;
    logic [31:0] a [0:3];
    logic [31:0] ox, oy, pc;
    pre = loaded_prefix();
    for (int i = 0; i < 4; i++) a[i] = $urandom_range(0, 1 << 15) - (1 << 14);
    ox = $urandom_range(0, 1 << 12) - (1 << 11);
    oy = $urandom_range(0, 1 << 12) - (1 << 11);
    pc = $urandom_range(0, pre);
    case (ph)
      2: begin
        for (int i = 0; i < 4; i++) a[i] = 32'h7fff_ffff;
        ox = 32'h007f_ffff; oy = 32'h007f_ffff; pc = pre;
      end
      3: begin
        for (int i = 0; i < 4; i++) a[i] = 32'h8000_0000;
        ox = 32'hff80_0000; oy = 32'hff80_0000; pc = 0;
      end
      5: begin
        for (int i = 0; i < 4; i++) a[i] = $urandom;
        ox = $urandom; oy = $urandom;
      end
      default: ;
    endcase
    // beyond the table size the count clamps
    if (pre == NumCentres && ph >= 6) pc = (ph == 6) ? 32'd127 : 32'd64;
    write_reg(REG_AFFINE_XX, a[0]);
    write_reg(REG_AFFINE_XY, a[1]);
    write_reg(REG_AFFINE_YX, a[2]);
    write_reg(REG_AFFINE_YY, a[3]);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_POINT_COUNT, pc);
    if (ph == 1) write_reg(RegUnmapped, $urandom);
  endtask

  // ---------------------------------------------------------------- output side
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        // long hold-off so the block backs up into its input
        @(negedge clk_i);
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      n = no_idle ? 0 : $urandom_range(0, 17);
      @(negedge clk_i);
      out_stall_i = (n > 0);
      if (n > 0) begin
        repeat (n - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i) && !hold_req);
    end
  end

  // Result check
  always @(posedge clk_i) begin
    warp_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_warps.size() == 0) begin
        $error("unexpected result beat x=%0d y=%0d", warped_x_o, warped_y_o);
        fail_count++;
      end else begin
        w = pending_warps.pop_front();
        if (warped_x_o !== w.wx) begin
          $error("warped_x expected %0d actual %0d", w.wx, warped_x_o);
          fail_count++;
        end
        if (warped_y_o !== w.wy) begin
          $error("warped_y expected %0d actual %0d", w.wy, warped_y_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main
  initial begin
    build_log_frac();
    for (int i = 0; i < 7; i++) cfg_reg[i] = '0;
    for (int i = 0; i < NumCentres; i++) begin
      cen_x[i] = '0; cen_y[i] = '0; wgt_x[i] = '0; wgt_y[i] = '0; loaded[i] = 1'b0;
    end
    // after reset: identity map, no centres
    add_row(OpEval, 6'd0, 24'sd0, 24'sd0, 32'sd0, 32'sd0, 1'b1);
    add_row(OpEval, 6'd63, 24'sh7fffff, 24'sh7fffff, 32'sd0, 32'sd0, 1'b1);
    add_row(OpEval, 6'd0, 24'sh800000, 24'sh800000, 32'sd0, 32'sd0, 1'b1);
    add_row(OpEval, 6'd21, 24'sh7fffff, 24'sh800000, 32'sd0, 32'sd0, 1'b1);
    add_row(OpEval, 6'd42, 24'sh800000, 24'sh7fffff, 32'sd0, 32'sd0, 1'b1);
    add_row(OpLoad, 6'd0, 24'sd0, 24'sd0, 32'sh7fffffff, 32'sh80000000, 1'b0);
    add_row(OpLoad, 6'd1, 24'sh7fffff, 24'sh800000, 32'sh80000000, 32'sh7fffffff, 1'b0);
    add_row(OpLoad, 6'd2, 24'sh800000, 24'sh7fffff, 32'sh00010000, 32'shffff0000, 1'b0);
    add_row(OpLoad, 6'd3, 24'sd100, -24'sd100, 32'sd0, 32'shffffffff, 1'b0);
    add_row(OpLoad, 6'd63, 24'sd5, 24'sd5, 32'sh12345678, -32'sh12345678, 1'b0);
    add_row(OpEval, 6'd0, 24'sd1, -24'sd1, 32'sd0, 32'sd0, 1'b0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) send_beat(dir_tab[i]);

    for (int ph = 1; ph <= NumPhases; ph++) begin
      wait_idle();
      configure(ph);
      no_idle = (ph % 3 == 2);
      if (ph == 4) hold_req = 1'b1;
      // extra evals at the extremes under each setting
      if (used_centres() <= loaded_prefix()) begin
        add_row(OpEval, 6'd0, 24'sh7fffff, 24'sh800000, 32'sd0, 32'sd0, 1'b0);
        send_beat(dir_tab[dir_tab.size() - 1]);
      end
      for (int k = 0; k < PhaseItems; k++) send_beat(rand_row());
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/tps_pkg.sv
rtl/core/tps_cell.sv
rtl/core/tps_kernel.sv
rtl/core/thin_plate_spline_warp_eval.sv
verif/thin_plate_spline_warp_eval_test.sv
